FILE: design/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared codes, constants, command struct and decode functions of the
// motor calibration sequencer.
// ----------------------------------------------------------------------------
package mcs_pkg;

   // field widths
   localparam int OP_W     = 2;
   localparam int DT_W     = 16;
   localparam int DATA_W   = 16;
   localparam int EFF_W    = 15;
   localparam int CODE_W   = 3;
   localparam int PROG_W   = 10;
   localparam int TIME_W   = 22;
   localparam int CSR_IDX_W = 1;
   localparam int MUL_W    = 32;
   localparam int PROD_W   = 2 * MUL_W;

   // opcodes
   localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
   localparam logic [OP_W-1:0] OP_BEGIN    = 2'd1;
   localparam logic [OP_W-1:0] OP_CANCEL   = 2'd2;
   localparam logic [OP_W-1:0] OP_SYS_LEFT = 2'd3;

   // run status
   localparam logic [CODE_W-1:0] RS_IDLE     = 3'd0;
   localparam logic [CODE_W-1:0] RS_RUNNING  = 3'd1;
   localparam logic [CODE_W-1:0] RS_CANCELED = 3'd2;
   localparam logic [CODE_W-1:0] RS_FAILED   = 3'd3;
   localparam logic [CODE_W-1:0] RS_COMPLETE = 3'd4;

   // phases
   localparam logic [CODE_W-1:0] PH_IDLE      = 3'd0;
   localparam logic [CODE_W-1:0] PH_STILL     = 3'd1;
   localparam logic [CODE_W-1:0] PH_LEFT_DIR  = 3'd2;
   localparam logic [CODE_W-1:0] PH_RIGHT_DIR = 3'd3;
   localparam logic [CODE_W-1:0] PH_LEFT_DZ   = 3'd4;
   localparam logic [CODE_W-1:0] PH_RIGHT_DZ  = 3'd5;
   localparam logic [CODE_W-1:0] PH_SUMMARY   = 3'd6;

   // end causes
   localparam logic [CODE_W-1:0] EC_NONE      = 3'd0;
   localparam logic [CODE_W-1:0] EC_CANCELED  = 3'd1;
   localparam logic [CODE_W-1:0] EC_TILT      = 3'd2;
   localparam logic [CODE_W-1:0] EC_LEFT_DIR  = 3'd3;
   localparam logic [CODE_W-1:0] EC_RIGHT_DIR = 3'd4;
   localparam logic [CODE_W-1:0] EC_STOPPED   = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_EFFORT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_EFFORT  = 1'b1;

   localparam logic signed [DATA_W-1:0] STEP_EFFORT_RESET = 16'sd6554;
   localparam logic [EFF_W-1:0]         MAX_EFFORT_RESET  = 15'd16384;

   // multiplier operand selects
   localparam logic [1:0] MUL_NONE       = 2'd0;
   localparam logic [1:0] MUL_PROG       = 2'd1;
   localparam logic [1:0] MUL_RAMP_SCALE = 2'd2;
   localparam logic [1:0] MUL_RAMP_RECIP = 2'd3;

   // timing
   localparam logic [TIME_W-1:0] T_STILL  = 22'd1200000;
   localparam logic [TIME_W-1:0] T_DIR    = 22'd800000;
   localparam logic [TIME_W-1:0] T_SWEEP  = 22'd2000000;
   localparam logic [TIME_W-1:0] T_SUM    = 22'd300000;
   localparam logic [TIME_W-1:0] TIME_MAX = 22'd4194303;

   // thresholds on magnitudes
   localparam logic [DATA_W:0] PITCH_SAFE     = 17'd2500;
   localparam logic [DATA_W:0] PITCH_STILL    = 17'd800;
   localparam logic [DATA_W:0] SPEED_SETTLED  = 17'd200;
   localparam logic [DATA_W:0] SPEED_RESPONSE = 17'd250;
   localparam logic [DATA_W:0] PEAK_SAT       = 17'd32767;

   localparam logic [EFF_W-1:0]  SWEEP_MIN = 15'd1311;
   localparam logic [EFF_W-1:0]  SWEEP_CAP = 15'd19661;
   localparam logic [PROG_W-1:0] PROG_FULL = 10'd1000;

   // progress spans and bases in per mille
   localparam longint unsigned SPAN_STILL = 200;
   localparam longint unsigned SPAN_DIR   = 150;
   localparam longint unsigned SPAN_DZ    = 200;
   localparam longint unsigned SPAN_SUM   = 100;

   // floor(span * t / dur) as (t * recip) >> PROG_SHIFT
   localparam int PROG_SHIFT = 42;
   localparam int PROG_Q_W   = 8;
   localparam longint unsigned PROG_ONE = 64'd1 << PROG_SHIFT;
   localparam logic [MUL_W-1:0] RECIP_STILL =
      32'((PROG_ONE * SPAN_STILL + 64'(T_STILL) - 1) / 64'(T_STILL));
   localparam logic [MUL_W-1:0] RECIP_DIR =
      32'((PROG_ONE * SPAN_DIR + 64'(T_DIR) - 1) / 64'(T_DIR));
   localparam logic [MUL_W-1:0] RECIP_DZ =
      32'((PROG_ONE * SPAN_DZ + 64'(T_SWEEP) - 1) / 64'(T_SWEEP));
   localparam logic [MUL_W-1:0] RECIP_SUM =
      32'((PROG_ONE * SPAN_SUM + 64'(T_SUM) - 1) / 64'(T_SUM));

   // ramp: floor(w * t / 2000000) = floor(floor(w * t / 128) / 15625)
   localparam int RAMP_PRE   = 7;
   localparam int RAMP_N_W   = 29;
   localparam int RAMP_SHIFT = 43;
   localparam longint unsigned RAMP_DIV = 64'(T_SWEEP) >> RAMP_PRE;
   localparam logic [MUL_W-1:0] RAMP_RECIP =
      32'(((64'd1 << RAMP_SHIFT) + RAMP_DIV - 1) / RAMP_DIV);

   typedef struct packed {
      logic       capture;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       prog_latch;
      logic       commit;
   } mcs_cmd_type;

   function automatic logic [PROG_W-1:0] base_pm(input logic [CODE_W-1:0] ph);
      logic [PROG_W-1:0] b;
      unique case (ph)
         PH_LEFT_DIR:  b = 10'd200;
         PH_RIGHT_DIR: b = 10'd350;
         PH_LEFT_DZ:   b = 10'd500;
         PH_RIGHT_DZ:  b = 10'd700;
         PH_SUMMARY:   b = 10'd900;
         default:      b = '0;
      endcase
      return b;
   endfunction

   function automatic logic [TIME_W-1:0] dur_us(input logic [CODE_W-1:0] ph);
      logic [TIME_W-1:0] d;
      unique case (ph)
         PH_STILL:                  d = T_STILL;
         PH_LEFT_DIR, PH_RIGHT_DIR: d = T_DIR;
         PH_LEFT_DZ, PH_RIGHT_DZ:   d = T_SWEEP;
         PH_SUMMARY:                d = T_SUM;
         default:                   d = 22'd1;
      endcase
      return d;
   endfunction

   function automatic logic [MUL_W-1:0] prog_recip(input logic [CODE_W-1:0] ph);
      logic [MUL_W-1:0] r;
      unique case (ph)
         PH_STILL:                  r = RECIP_STILL;
         PH_LEFT_DIR, PH_RIGHT_DIR: r = RECIP_DIR;
         PH_LEFT_DZ, PH_RIGHT_DZ:   r = RECIP_DZ;
         PH_SUMMARY:                r = RECIP_SUM;
         default:                   r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [DATA_W:0] abs17(input logic signed [DATA_W-1:0] v);
      logic [DATA_W:0] ext;
      ext = {v[DATA_W-1], v};
      return v[DATA_W-1] ? (~ext + 17'd1) : ext;
   endfunction

endpackage

FILE: design/mcs_if.sv
// ----------------------------------------------------------------------------
// mcs_req_if / mcs_rsp_if
// Valid/ready channels carrying tick items and result items.
// ----------------------------------------------------------------------------
interface mcs_req_if
   import mcs_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          opcode;
   logic [DT_W-1:0]          dt_us;
   logic signed [DATA_W-1:0] pitch_cdeg;
   logic signed [DATA_W-1:0] left_speed;
   logic signed [DATA_W-1:0] right_speed;

   modport source (output valid, opcode, dt_us, pitch_cdeg, left_speed, right_speed,
                   input ready);
   modport sink (input valid, opcode, dt_us, pitch_cdeg, left_speed, right_speed,
                 output ready);
endinterface

interface mcs_rsp_if
   import mcs_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] drive_left;
   logic signed [DATA_W-1:0] drive_right;
   logic [CODE_W-1:0]        run_state;
   logic [CODE_W-1:0]        phase_now;
   logic [PROG_W-1:0]        progress_pm;
   logic                     left_dir_good;
   logic                     right_dir_good;
   logic [EFF_W-1:0]         left_dz_level;
   logic [EFF_W-1:0]         right_dz_level;
   logic                     finished;
   logic [CODE_W-1:0]        end_cause;

   modport source (output valid, drive_left, drive_right, run_state, phase_now,
                   progress_pm, left_dir_good, right_dir_good, left_dz_level,
                   right_dz_level, finished, end_cause,
                   input ready);
   modport sink (input valid, drive_left, drive_right, run_state, phase_now,
                 progress_pm, left_dir_good, right_dir_good, left_dz_level,
                 right_dz_level, finished, end_cause,
                 output ready);
endinterface

FILE: design/motor_calibration_sequencer_core.sv
// ----------------------------------------------------------------------------
// motor_calibration_sequencer_core
// Two-wheel motor calibration sequencer: stillness hold, direction checks,
// deadzone ramps and summary, with progress and finish reporting.
// ----------------------------------------------------------------------------
// The result register is loaded when an accepted item completes its steps: the time
// step is added as the item is captured, then come three passes through the
// single 32x32 multiplier (progress reciprocal, ramp scale, ramp reciprocal)
// and one commit cycle that updates the calibration state and loads the
// result. req_chan.ready is high only while the sequencer is idle, which it
// is again on the cycle after the commit, so a new item is taken only after
// the previous one has committed. A result waiting in the output register
// does not block the next item, but the commit of that next item waits until
// the previous result has been taken.
module motor_calibration_sequencer_core
   import mcs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   mcs_req_if.sink              req_chan,
   mcs_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   mcs_cmd_type cmd;

   mcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   mcs_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_opcode         (req_chan.opcode),
      .req_dt_us          (req_chan.dt_us),
      .req_pitch_cdeg     (req_chan.pitch_cdeg),
      .req_left_speed     (req_chan.left_speed),
      .req_right_speed    (req_chan.right_speed),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_drive_left     (rsp_chan.drive_left),
      .rsp_drive_right    (rsp_chan.drive_right),
      .rsp_run_state      (rsp_chan.run_state),
      .rsp_phase_now      (rsp_chan.phase_now),
      .rsp_progress_pm    (rsp_chan.progress_pm),
      .rsp_left_dir_good  (rsp_chan.left_dir_good),
      .rsp_right_dir_good (rsp_chan.right_dir_good),
      .rsp_left_dz_level  (rsp_chan.left_dz_level),
      .rsp_right_dz_level (rsp_chan.right_dz_level),
      .rsp_finished       (rsp_chan.finished),
      .rsp_end_cause      (rsp_chan.end_cause)
   );

`ifndef SYNTHESIS
   // one item in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("item accepted while previous item in flight");

   // a finished run never drives the motors
   a_fin_no_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.finished |->
         (rsp_chan.drive_left == '0) && (rsp_chan.drive_right == '0))
      else $error("motor effort on finishing item");

   // cause code only with finish
   a_cause_needs_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.finished |-> rsp_chan.end_cause == EC_NONE)
      else $error("end cause without finish");

   // idle phase carries zero progress
   a_idle_progress: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.phase_now == PH_IDLE) |->
         rsp_chan.progress_pm == '0)
      else $error("progress reported in idle phase");
`endif

endmodule

FILE: design/mcs_ctrl.sv
// ----------------------------------------------------------------------------
// mcs_ctrl
// Sequencer: accepts an item, walks it through three multiplier passes and
// a commit cycle, and holds the result valid flag.
// ----------------------------------------------------------------------------
module mcs_ctrl
   import mcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output mcs_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PROG  = 3'd1;
   localparam logic [2:0] ST_RAMP1 = 3'd2;
   localparam logic [2:0] ST_RAMP2 = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free  = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in       = state_ff;
      cmd.capture    = 1'b0;
      cmd.mul_en     = 1'b0;
      cmd.mul_sel    = MUL_NONE;
      cmd.prog_latch = 1'b0;
      cmd.commit     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PROG;
            end
         end
         ST_PROG: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_PROG;
            state_in    = ST_RAMP1;
         end
         ST_RAMP1: begin
            cmd.mul_en     = 1'b1;
            cmd.mul_sel    = MUL_RAMP_SCALE;
            cmd.prog_latch = 1'b1;
            state_in       = ST_RAMP2;
         end
         ST_RAMP2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_RAMP_RECIP;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.commit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: design/mcs_dp.sv
// ----------------------------------------------------------------------------
// mcs_dp
// Datapath: input capture, calibration state, configuration registers,
// shared multiplier and the result register.
// ----------------------------------------------------------------------------
module mcs_dp
   import mcs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  mcs_cmd_type              cmd,
   input  logic [OP_W-1:0]          req_opcode,
   input  logic [DT_W-1:0]          req_dt_us,
   input  logic signed [DATA_W-1:0] req_pitch_cdeg,
   input  logic signed [DATA_W-1:0] req_left_speed,
   input  logic signed [DATA_W-1:0] req_right_speed,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata,
   output logic signed [DATA_W-1:0] rsp_drive_left,
   output logic signed [DATA_W-1:0] rsp_drive_right,
   output logic [CODE_W-1:0]        rsp_run_state,
   output logic [CODE_W-1:0]        rsp_phase_now,
   output logic [PROG_W-1:0]        rsp_progress_pm,
   output logic                     rsp_left_dir_good,
   output logic                     rsp_right_dir_good,
   output logic [EFF_W-1:0]         rsp_left_dz_level,
   output logic [EFF_W-1:0]         rsp_right_dz_level,
   output logic                     rsp_finished,
   output logic [CODE_W-1:0]        rsp_end_cause
);

   // configuration
   logic signed [DATA_W-1:0] step_eff_ff;
   logic [EFF_W-1:0]         max_eff_ff;

   // captured item
   logic [OP_W-1:0]          op_ff;
   logic [DT_W-1:0]          dt_ff;
   logic signed [DATA_W-1:0] pitch_ff;
   logic signed [DATA_W-1:0] lspd_ff;
   logic signed [DATA_W-1:0] rspd_ff;
   logic [TIME_W-1:0]        tnew_ff, tnew_in;
   logic [TIME_W:0]          tsum;

   // calibration state
   logic [CODE_W-1:0] status_ff, status_in;
   logic [CODE_W-1:0] phase_ff, phase_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [EFF_W-1:0]  peak_ff, peak_in;
   logic              pending_ff, pending_in;
   logic              lok_ff, lok_in;
   logic              rok_ff, rok_in;
   logic [EFF_W-1:0]  ldz_ff, ldz_in;
   logic [EFF_W-1:0]  rdz_ff, rdz_in;
   logic [PROG_W-1:0] prog_ff, prog_in;

   // multiplier
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [PROG_W-1:0] pcalc_ff, pcalc_in;
   logic [TIME_W-1:0] tprog, tramp, pdur;

   // tick decode
   logic                     running, is_left, still_bad, dir_ok, sel_pos, fin;
   logic [DATA_W:0]          pitch_abs, labs, rabs, sel_abs;
   logic signed [DATA_W-1:0] sel_spd;
   logic [EFF_W-1:0]         sel_sat, peak_new, cap, top, sweep_w, sweep_e;
   logic signed [DATA_W-1:0] lim, nlim, dir_eff, drv_l, drv_r;
   logic [CODE_W-1:0]        phase_next, cause;

   // time step with saturation
   assign tsum    = {1'b0, time_ff} + (TIME_W + 1)'(req_dt_us);
   assign tnew_in = tsum[TIME_W] ? TIME_MAX : tsum[TIME_W-1:0];

   // multiplier operands
   assign pdur  = dur_us(phase_ff);
   assign tprog = (tnew_ff < pdur) ? tnew_ff : pdur;
   assign tramp = (tnew_ff < T_SWEEP) ? tnew_ff : T_SWEEP;

   assign cap     = (max_eff_ff < SWEEP_CAP) ? max_eff_ff : SWEEP_CAP;
   assign top     = (cap < SWEEP_MIN) ? SWEEP_MIN : cap;
   assign sweep_w = top - SWEEP_MIN;

   always_comb begin
      case (cmd.mul_sel)
         MUL_PROG: begin
            mul_a = MUL_W'(tprog);
            mul_b = prog_recip(phase_ff);
         end
         MUL_RAMP_SCALE: begin
            mul_a = MUL_W'(sweep_w);
            mul_b = MUL_W'(tramp);
         end
         MUL_RAMP_RECIP: begin
            mul_a = MUL_W'(prod_ff[RAMP_PRE+RAMP_N_W-1:RAMP_PRE]);
            mul_b = RAMP_RECIP;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign pcalc_in = base_pm(phase_ff)
                   + PROG_W'(prod_ff[PROG_SHIFT+PROG_Q_W-1:PROG_SHIFT]);
   assign sweep_e  = SWEEP_MIN + prod_ff[RAMP_SHIFT+EFF_W-1:RAMP_SHIFT];

   // tick decode
   assign running   = (status_ff == RS_RUNNING);
   assign is_left   = (phase_ff == PH_LEFT_DIR) || (phase_ff == PH_LEFT_DZ);
   assign pitch_abs = abs17(pitch_ff);
   assign labs      = abs17(lspd_ff);
   assign rabs      = abs17(rspd_ff);
   assign sel_spd   = is_left ? lspd_ff : rspd_ff;
   assign sel_abs   = is_left ? labs : rabs;
   assign sel_sat   = (sel_abs > PEAK_SAT) ? PEAK_SAT[EFF_W-1:0] : sel_abs[EFF_W-1:0];
   assign peak_new  = (sel_sat > peak_ff) ? sel_sat : peak_ff;
   assign sel_pos   = !sel_spd[DATA_W-1] && (sel_spd != '0);
   assign dir_ok    = ({2'b00, peak_new} >= SPEED_RESPONSE) && sel_pos;
   assign still_bad = (pitch_abs > PITCH_STILL) || (labs > SPEED_SETTLED)
                   || (rabs > SPEED_SETTLED);
   assign phase_next = phase_ff + 3'd1;

   assign lim     = signed'({1'b0, max_eff_ff});
   assign nlim    = -lim;
   assign dir_eff = (step_eff_ff > lim) ? lim : ((step_eff_ff < nlim) ? nlim : step_eff_ff);

   always_comb begin
      status_in  = status_ff;
      phase_in   = phase_ff;
      time_in    = time_ff;
      peak_in    = peak_ff;
      pending_in = pending_ff;
      lok_in     = lok_ff;
      rok_in     = rok_ff;
      ldz_in     = ldz_ff;
      rdz_in     = rdz_ff;
      prog_in    = prog_ff;
      drv_l      = '0;
      drv_r      = '0;
      fin        = 1'b0;
      cause      = EC_NONE;
      unique case (op_ff)
         OP_BEGIN: begin
            status_in  = RS_RUNNING;
            lok_in     = 1'b0;
            rok_in     = 1'b0;
            ldz_in     = '0;
            rdz_in     = '0;
            pending_in = 1'b0;
            phase_in   = PH_STILL;
            time_in    = '0;
            peak_in    = '0;
            prog_in    = base_pm(PH_STILL);
         end
         OP_CANCEL: begin
            if (running) begin
               pending_in = 1'b1;
            end
         end
         OP_SYS_LEFT: begin
            if (running) begin
               status_in  = RS_CANCELED;
               phase_in   = PH_IDLE;
               prog_in    = '0;
               pending_in = 1'b0;
               fin        = 1'b1;
               cause      = EC_STOPPED;
            end
         end
         OP_TICK: begin
            if (running && (dt_ff != '0)) begin
               if (pending_ff) begin
                  status_in  = RS_CANCELED;
                  phase_in   = PH_IDLE;
                  prog_in    = '0;
                  pending_in = 1'b0;
                  fin        = 1'b1;
                  cause      = EC_CANCELED;
               end else if (pitch_abs > PITCH_SAFE) begin
                  status_in  = RS_FAILED;
                  phase_in   = PH_IDLE;
                  prog_in    = '0;
                  pending_in = 1'b0;
                  fin        = 1'b1;
                  cause      = EC_TILT;
               end else begin
                  time_in = tnew_ff;
                  prog_in = pcalc_ff;
                  case (phase_ff) inside
                     PH_STILL: begin
                        if (still_bad) begin
                           time_in = '0;
                        end else if (tnew_ff >= T_STILL) begin
                           phase_in = PH_LEFT_DIR;
                           time_in  = '0;
                           peak_in  = '0;
                           prog_in  = base_pm(PH_LEFT_DIR);
                        end
                     end
                     PH_LEFT_DIR, PH_RIGHT_DIR: begin
                        if (is_left) begin
                           drv_l = dir_eff;
                        end else begin
                           drv_r = dir_eff;
                        end
                        peak_in = peak_new;
                        if (tnew_ff >= T_DIR) begin
                           if (is_left) begin
                              lok_in = dir_ok;
                           end else begin
                              rok_in = dir_ok;
                           end
                           if (!dir_ok) begin
                              status_in  = RS_FAILED;
                              phase_in   = PH_IDLE;
                              prog_in    = '0;
                              pending_in = 1'b0;
                              fin        = 1'b1;
                              cause      = is_left ? EC_LEFT_DIR : EC_RIGHT_DIR;
                           end else begin
                              phase_in = phase_next;
                              time_in  = '0;
                              peak_in  = '0;
                              prog_in  = base_pm(phase_next);
                           end
                        end
                     end
                     PH_LEFT_DZ, PH_RIGHT_DZ: begin
                        if (is_left) begin
                           drv_l = signed'({1'b0, sweep_e});
                           if ((ldz_ff == '0) && (labs >= SPEED_RESPONSE)) begin
                              ldz_in = sweep_e;
                           end
                        end else begin
                           drv_r = signed'({1'b0, sweep_e});
                           if ((rdz_ff == '0) && (rabs >= SPEED_RESPONSE)) begin
                              rdz_in = sweep_e;
                           end
                        end
                        if (tnew_ff >= T_SWEEP) begin
                           phase_in = phase_next;
                           time_in  = '0;
                           peak_in  = '0;
                           prog_in  = base_pm(phase_next);
                        end
                     end
                     PH_SUMMARY: begin
                        if (tnew_ff >= T_SUM) begin
                           status_in = RS_COMPLETE;
                           prog_in   = PROG_FULL;
                           fin       = 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         default: begin
         end
      endcase
      if (fin) begin
         drv_l = '0;
         drv_r = '0;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_eff_ff <= STEP_EFFORT_RESET;
         max_eff_ff  <= MAX_EFFORT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_STEP_EFFORT: step_eff_ff <= signed'(csr_wdata);
            CSR_MAX_EFFORT:  max_eff_ff  <= csr_wdata[EFF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // captured item and arithmetic pipeline
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         dt_ff    <= req_dt_us;
         pitch_ff <= req_pitch_cdeg;
         lspd_ff  <= req_left_speed;
         rspd_ff  <= req_right_speed;
         tnew_ff  <= tnew_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.prog_latch) begin
         pcalc_ff <= pcalc_in;
      end
   end

   // calibration state
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff  <= RS_IDLE;
         phase_ff   <= PH_IDLE;
         time_ff    <= '0;
         peak_ff    <= '0;
         pending_ff <= 1'b0;
         lok_ff     <= 1'b0;
         rok_ff     <= 1'b0;
         ldz_ff     <= '0;
         rdz_ff     <= '0;
         prog_ff    <= '0;
      end else if (cmd.commit) begin
         status_ff  <= status_in;
         phase_ff   <= phase_in;
         time_ff    <= time_in;
         peak_ff    <= peak_in;
         pending_ff <= pending_in;
         lok_ff     <= lok_in;
         rok_ff     <= rok_in;
         ldz_ff     <= ldz_in;
         rdz_ff     <= rdz_in;
         prog_ff    <= prog_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_drive_left     <= drv_l;
         rsp_drive_right    <= drv_r;
         rsp_run_state      <= status_in;
         rsp_phase_now      <= phase_in;
         rsp_progress_pm    <= prog_in;
         rsp_left_dir_good  <= lok_in;
         rsp_right_dir_good <= rok_in;
         rsp_left_dz_level  <= ldz_in;
         rsp_right_dz_level <= rdz_in;
         rsp_finished       <= fin;
         rsp_end_cause      <= cause;
      end
   end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for motor_calibration_sequencer_core. Directed items
// cover idle opcodes, stillness restarts, cancel, tilt and system-left stops;
// random calibration runs then walk every phase under several effort limits.
// Each result item is checked field by field against an in-bench predictor.
// ----------------------------------------------------------------------------
module testbench
   import mcs_pkg::*;
();

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [DT_W-1:0]          dt;
      logic signed [DATA_W-1:0] pitch;
      logic signed [DATA_W-1:0] left_spd;
      logic signed [DATA_W-1:0] right_spd;
   } tick_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] drive_left;
      logic signed [DATA_W-1:0] drive_right;
      logic [CODE_W-1:0]        run_state;
      logic [CODE_W-1:0]        phase_now;
      logic [PROG_W-1:0]        progress_pm;
      logic                     left_dir_good;
      logic                     right_dir_good;
      logic [EFF_W-1:0]         left_dz_level;
      logic [EFF_W-1:0]         right_dz_level;
      logic                     finished;
      logic [CODE_W-1:0]        end_cause;
   } calib_report_type;

   localparam int TILT_LIMIT     = 2500;
   localparam int STILL_PITCH    = 800;
   localparam int STILL_SPEED    = 200;
   localparam int RESPONSE_SPEED = 250;
   localparam int RAMP_LOW       = 1311;
   localparam int RAMP_HIGH      = 19661;
   localparam int unsigned TIME_SAT = 4194303;
   localparam int unsigned HOLD_US [7] = '{1, 1200000, 800000, 800000, 2000000, 2000000, 300000};
   localparam int unsigned PM_BASE [7] = '{0, 0, 200, 350, 500, 700, 900};
   localparam int unsigned PM_SPAN [7] = '{0, 200, 150, 150, 200, 200, 100};

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_wdata;

   mcs_req_if req_if ();
   mcs_rsp_if rsp_if ();

   motor_calibration_sequencer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // predictor state
   int          cfg_step;
   int          cfg_max;
   logic [2:0]  cal_status;
   logic [2:0]  cal_phase;
   int unsigned cal_time;
   int          cal_peak;
   int          cal_latest;
   logic        cal_cancel;
   logic        cal_left_ok;
   logic        cal_right_ok;
   int          cal_left_dz;
   int          cal_right_dz;
   int          cal_progress;

   calib_report_type pending_reports[$];
   int error_count   = 0;
   int src_idle_pct  = 21;
   int sink_idle_pct = 45;
   int run_noise_pct = 0;

   function automatic int magnitude(int v);
      return v < 0 ? -v : v;
   endfunction

   function automatic int rand_between(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic void update_progress();
      int unsigned t;
      if (cal_phase < PH_STILL || cal_phase > PH_SUMMARY) begin
         cal_progress = 0;
      end else begin
         t = cal_time < HOLD_US[cal_phase] ? cal_time : HOLD_US[cal_phase];
         cal_progress = PM_BASE[cal_phase] +
            int'((longint'(PM_SPAN[cal_phase]) * longint'(t)) / longint'(HOLD_US[cal_phase]));
      end
   endfunction

   function automatic void enter_phase(logic [2:0] ph);
      cal_phase = ph;
      cal_time = 0;
      cal_peak = 0;
      cal_latest = 0;
      update_progress();
   endfunction

   function automatic void close_run(logic [2:0] status);
      cal_status = status;
      cal_phase = PH_IDLE;
      cal_progress = 0;
      cal_cancel = 1'b0;
   endfunction

   function automatic int clamped_step();
      int v;
      v = cfg_step;
      if (v > cfg_max) v = cfg_max;
      if (v < -cfg_max) v = -cfg_max;
      return v;
   endfunction

   function automatic int ramp_effort();
      int top;
      int unsigned t;
      top = cfg_max < RAMP_HIGH ? cfg_max : RAMP_HIGH;
      if (top < RAMP_LOW) top = RAMP_LOW;
      t = cal_time < HOLD_US[PH_LEFT_DZ] ? cal_time : HOLD_US[PH_LEFT_DZ];
      return RAMP_LOW + int'((longint'(top - RAMP_LOW) * longint'(t)) /
                             longint'(HOLD_US[PH_LEFT_DZ]));
   endfunction

   function automatic calib_report_type advance_calibration(tick_item_type it);
      calib_report_type r;
      logic       ended;
      logic       is_left;
      logic       ok;
      logic [2:0] cause;
      int         pitch_mag;
      int         drive_l;
      int         drive_r;
      int         spd;
      int         effort;
      ended = 1'b0;
      cause = EC_NONE;
      drive_l = 0;
      drive_r = 0;
      pitch_mag = magnitude(it.pitch);
      if (it.op == OP_BEGIN) begin
         cal_status = RS_RUNNING;
         cal_left_ok = 1'b0;
         cal_right_ok = 1'b0;
         cal_left_dz = 0;
         cal_right_dz = 0;
         cal_cancel = 1'b0;
         enter_phase(PH_STILL);
      end else if (it.op == OP_CANCEL) begin
         if (cal_status == RS_RUNNING) cal_cancel = 1'b1;
      end else if (it.op == OP_SYS_LEFT) begin
         if (cal_status == RS_RUNNING) begin
            close_run(RS_CANCELED);
            ended = 1'b1;
            cause = EC_STOPPED;
         end
      end else if (cal_status == RS_RUNNING && it.dt != 0) begin
         if (cal_cancel) begin
            close_run(RS_CANCELED);
            ended = 1'b1;
            cause = EC_CANCELED;
         end else if (pitch_mag > TILT_LIMIT) begin
            close_run(RS_FAILED);
            ended = 1'b1;
            cause = EC_TILT;
         end else begin
            cal_time = cal_time + it.dt;
            if (cal_time > TIME_SAT) cal_time = TIME_SAT;
            update_progress();
            case (cal_phase)
               PH_STILL: begin
                  if (pitch_mag > STILL_PITCH || magnitude(it.left_spd) > STILL_SPEED ||
                      magnitude(it.right_spd) > STILL_SPEED)
                     cal_time = 0;
                  else if (cal_time >= HOLD_US[PH_STILL])
                     enter_phase(PH_LEFT_DIR);
               end
               PH_LEFT_DIR, PH_RIGHT_DIR: begin
                  is_left = (cal_phase == PH_LEFT_DIR);
                  effort = clamped_step();
                  if (is_left) drive_l = effort; else drive_r = effort;
                  spd = is_left ? int'(it.left_spd) : int'(it.right_spd);
                  cal_latest = spd;
                  if (magnitude(spd) > 32767) spd = 32767;
                  if (magnitude(spd) > cal_peak) cal_peak = magnitude(spd);
                  if (cal_time >= HOLD_US[PH_LEFT_DIR]) begin
                     ok = cal_peak >= RESPONSE_SPEED && cal_latest > 0;
                     if (is_left) cal_left_ok = ok; else cal_right_ok = ok;
                     if (!ok) begin
                        close_run(RS_FAILED);
                        ended = 1'b1;
                        cause = is_left ? EC_LEFT_DIR : EC_RIGHT_DIR;
                     end else begin
                        enter_phase(is_left ? PH_RIGHT_DIR : PH_LEFT_DZ);
                     end
                  end
               end
               PH_LEFT_DZ, PH_RIGHT_DZ: begin
                  is_left = (cal_phase == PH_LEFT_DZ);
                  effort = ramp_effort();
                  spd = is_left ? int'(it.left_spd) : int'(it.right_spd);
                  if (is_left) begin
                     drive_l = effort;
                     if (cal_left_dz == 0 && magnitude(spd) >= RESPONSE_SPEED)
                        cal_left_dz = effort;
                  end else begin
                     drive_r = effort;
                     if (cal_right_dz == 0 && magnitude(spd) >= RESPONSE_SPEED)
                        cal_right_dz = effort;
                  end
                  if (cal_time >= HOLD_US[PH_LEFT_DZ])
                     enter_phase(is_left ? PH_RIGHT_DZ : PH_SUMMARY);
               end
               PH_SUMMARY: begin
                  if (cal_time >= HOLD_US[PH_SUMMARY]) begin
                     cal_status = RS_COMPLETE;
                     cal_progress = 1000;
                     ended = 1'b1;
                     cause = EC_NONE;
                  end
               end
               default: ;
            endcase
         end
      end
      if (ended) begin
         drive_l = 0;
         drive_r = 0;
      end
      r.drive_left     = 16'(drive_l);
      r.drive_right    = 16'(drive_r);
      r.run_state      = cal_status;
      r.phase_now      = cal_phase;
      r.progress_pm    = 10'(cal_progress);
      r.left_dir_good  = cal_left_ok;
      r.right_dir_good = cal_right_ok;
      r.left_dz_level  = 15'(cal_left_dz);
      r.right_dz_level = 15'(cal_right_dz);
      r.finished       = ended;
      r.end_cause      = cause;
      return r;
   endfunction

   function automatic tick_item_type make_item(logic [1:0] op, int dt, int pitch, int ls,
                                               int rs);
      tick_item_type t;
      t.op = op;
      t.dt = 16'(dt);
      t.pitch = 16'(pitch);
      t.left_spd = 16'(ls);
      t.right_spd = 16'(rs);
      return t;
   endfunction

   function automatic tick_item_type random_noise();
      return make_item(2'($urandom_range(3)), int'($urandom_range(65535)),
                       rand_between(-32768, 32767), rand_between(-32768, 32767),
                       rand_between(-32768, 32767));
   endfunction

   function automatic int wheel_speed_for(logic [2:0] ph, logic [2:0] dir_ph, logic [2:0] dz_ph);
      int roll;
      roll = $urandom_range(99);
      if (ph == dir_ph) begin
         if (roll < 85) return rand_between(250, 6000);
         if (roll < 90) begin
            case ($urandom_range(5))
               0: return 249;
               1: return 250;
               2: return -250;
               3: return 0;
               4: return -32768;
               default: return 32767;
            endcase
         end
         return rand_between(-32768, 32767);
      end
      if (ph == dz_ph) begin
         if (roll < 5) return rand_between(250, 9000);
         if (roll < 10) return rand_between(-9000, -250);
         if (roll < 13) begin
            case ($urandom_range(4))
               0: return 249;
               1: return 250;
               2: return -249;
               3: return -250;
               default: return -32768;
            endcase
         end
         return rand_between(-249, 249);
      end
      return rand_between(-STILL_SPEED, STILL_SPEED);
   endfunction

   // a tick shaped for the current phase of the predicted run
   function automatic tick_item_type random_run_tick();
      tick_item_type t;
      int roll;
      int pitch;
      int dt;
      roll = $urandom_range(99);
      if (roll < 75) dt = rand_between(30000, 65535);
      else if (roll < 96) dt = rand_between(1, 29999);
      else dt = 0;
      roll = $urandom_range(999);
      if (roll < 5) begin
         pitch = rand_between(2501, 18000);
         if ($urandom_range(1)) pitch = -pitch;
      end else if (roll < 20) begin
         case ($urandom_range(5))
            0: pitch = -2500;
            1: pitch = -801;
            2: pitch = -800;
            3: pitch = 800;
            4: pitch = 801;
            default: pitch = 2500;
         endcase
      end else begin
         pitch = rand_between(-STILL_PITCH, STILL_PITCH);
      end
      t = make_item(OP_TICK, dt, pitch,
                    wheel_speed_for(cal_phase, PH_LEFT_DIR, PH_LEFT_DZ),
                    wheel_speed_for(cal_phase, PH_RIGHT_DIR, PH_RIGHT_DZ));
      if (cal_phase == PH_STILL && $urandom_range(99) < 2) begin
         if ($urandom_range(1)) t.left_spd = 16'(rand_between(201, 2000));
         else t.right_spd = 16'(rand_between(-2000, -201));
      end
      return t;
   endfunction

   task automatic send_item(tick_item_type it);
      pending_reports.push_back(advance_calibration(it));
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.opcode      <= it.op;
      req_if.dt_us       <= it.dt;
      req_if.pitch_cdeg  <= it.pitch;
      req_if.left_speed  <= it.left_spd;
      req_if.right_speed <= it.right_spd;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_limits(logic [15:0] step, logic [15:0] lim);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_STEP_EFFORT;
      csr_wdata <= step;
      @(posedge clock);
      csr_index <= CSR_MAX_EFFORT;
      csr_wdata <= lim;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_step = int'(signed'(step));
      cfg_max = int'(lim[14:0]);
   endtask

   task automatic compare_field(string name, logic signed [31:0] want_v,
                                logic signed [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         error_count++;
      end
   endtask

   task automatic check_report();
      calib_report_type want;
      if (pending_reports.size() == 0) begin
         $error("result item with no expectation waiting");
         error_count++;
         return;
      end
      want = pending_reports.pop_front();
      compare_field("drive_left", want.drive_left, rsp_if.drive_left);
      compare_field("drive_right", want.drive_right, rsp_if.drive_right);
      compare_field("run_state", want.run_state, rsp_if.run_state);
      compare_field("phase_now", want.phase_now, rsp_if.phase_now);
      compare_field("progress_pm", want.progress_pm, rsp_if.progress_pm);
      compare_field("left_dir_good", want.left_dir_good, rsp_if.left_dir_good);
      compare_field("right_dir_good", want.right_dir_good, rsp_if.right_dir_good);
      compare_field("left_dz_level", want.left_dz_level, rsp_if.left_dz_level);
      compare_field("right_dz_level", want.right_dz_level, rsp_if.right_dz_level);
      compare_field("finished", want.finished, rsp_if.finished);
      compare_field("end_cause", want.end_cause, rsp_if.end_cause);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) check_report();
         rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   task automatic test_idle_items();
      send_item(make_item(OP_TICK, 65535, -32768, 32767, -32768));
      send_item(make_item(OP_TICK, 0, 32767, -32768, 32767));
      send_item(make_item(OP_CANCEL, 1, 0, 0, 0));
      send_item(make_item(OP_SYS_LEFT, 65535, -1, -1, -1));
   endtask

   task automatic test_stillness_hold();
      send_item(make_item(OP_BEGIN, 0, 0, 0, 0));
      send_item(make_item(OP_TICK, 0, 0, 0, 0));
      send_item(make_item(OP_TICK, 65535, 801, 0, 0));
      send_item(make_item(OP_TICK, 65535, 800, 200, -200));
      send_item(make_item(OP_TICK, 65535, 0, -32768, 0));
      send_item(make_item(OP_TICK, 1, -800, 0, 201));
      // restart in the middle of a run
      send_item(make_item(OP_BEGIN, 65535, 0, 0, 0));
   endtask

   task automatic test_cancel();
      send_item(make_item(OP_CANCEL, 0, 0, 0, 0));
      send_item(make_item(OP_TICK, 0, 0, 0, 0));
      // cancel wins over tilt
      send_item(make_item(OP_TICK, 1, 3000, 0, 0));
      send_item(make_item(OP_TICK, 65535, 0, 0, 0));
      send_item(make_item(OP_SYS_LEFT, 0, 0, 0, 0));
   endtask

   task automatic test_tilt_and_stop();
      send_item(make_item(OP_BEGIN, 0, 0, 0, 0));
      send_item(make_item(OP_TICK, 100, 2500, 0, 0));
      send_item(make_item(OP_TICK, 100, -2501, 0, 0));
      send_item(make_item(OP_BEGIN, 0, 0, 0, 0));
      send_item(make_item(OP_SYS_LEFT, 0, 0, 0, 0));
   endtask

   task automatic test_random_runs(int count, int src_pct, int snk_pct);
      tick_item_type t;
      int k;
      src_idle_pct = src_pct;
      sink_idle_pct = snk_pct;
      for (k = 0; k < count; k++) begin
         if (cal_status != RS_RUNNING)
            t = ($urandom_range(99) < 80) ? make_item(OP_BEGIN, int'($urandom_range(65535)),
                rand_between(-32768, 32767), rand_between(-32768, 32767),
                rand_between(-32768, 32767)) : random_noise();
         else if ($urandom_range(99) < run_noise_pct)
            t = random_noise();
         else
            t = random_run_tick();
         if (t.op == OP_BEGIN) run_noise_pct = ($urandom_range(3) == 0) ? 6 : 0;
         send_item(t);
      end
   endtask

   initial begin
      cfg_step = 6554;
      cfg_max = 16384;
      cal_status = RS_IDLE;
      cal_phase = PH_IDLE;
      cal_time = 0;
      cal_peak = 0;
      cal_latest = 0;
      cal_cancel = 1'b0;
      cal_left_ok = 1'b0;
      cal_right_ok = 1'b0;
      cal_left_dz = 0;
      cal_right_dz = 0;
      cal_progress = 0;
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_index          <= CSR_STEP_EFFORT;
      csr_wdata          <= '0;
      req_if.valid       <= 1'b0;
      req_if.opcode      <= OP_TICK;
      req_if.dt_us       <= '0;
      req_if.pitch_cdeg  <= '0;
      req_if.left_speed  <= '0;
      req_if.right_speed <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      set_limits(16'd6554, 16'd16384);
      test_idle_items();
      test_stillness_hold();
      test_cancel();
      test_tilt_and_stop();

      set_limits(16'h8000, 16'd0);
      test_random_runs(75, 21, 45);
      set_limits(16'h7fff, 16'h7fff);
      test_random_runs(75, 21, 45);
      set_limits(16'hffff, 16'd1311);
      test_random_runs(75, 45, 21);
      set_limits(16'd500, 16'd19661);
      test_random_runs(75, 45, 21);
      set_limits(16'($urandom), 16'($urandom));
      test_random_runs(75, 0, 0);
      set_limits(16'd6554, 16'd16384);
      test_random_runs(75, 0, 0);

      wait_drained();
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #1600000;
      $display("tb: failure");
      $finish;
   end

endmodule
